/* hdl/crpi_pkg.sv */
// Shared widths, constants and stage-enable types for the Catmull-Rom point interpolator.
package crpi_pkg;

  // Field widths
  localparam int unsigned CoordW  = 16;
  localparam int unsigned FracW   = 16;
  localparam int unsigned NumPts  = 4;
  // Weights are signed Q2.16 carried with headroom for the intermediate sums
  localparam int unsigned WeightW = 20;
  localparam int unsigned ProdW   = WeightW + CoordW;
  localparam int unsigned SumW    = ProdW + 2;

  // Stream payload widths
  localparam int unsigned CrdW     = 2 * NumPts * CoordW;
  localparam int unsigned InDataW  = CrdW + FracW;
  localparam int unsigned OutDataW = 2 * CoordW;

  // Pipeline depth from the input transaction to the output register
  localparam int unsigned NumStages = 7;

  // Fixed-point constants
  localparam logic signed [WeightW-1:0] OneQ16     = 20'sd65536;
  localparam logic signed [WeightW-1:0] HalfLsbW   = 20'sd1;
  localparam logic [2*FracW:0]          HalfQ16U   = 33'd32768;
  localparam logic signed [SumW-1:0]    HalfQ16S   = 38'sd32768;
  localparam logic signed [SumW-1:0]    CoordMaxS  = 38'sd32767;
  localparam logic signed [SumW-1:0]    CoordMinS  = -38'sd32768;
  localparam logic signed [CoordW-1:0]  CoordMax   = 16'sh7fff;
  localparam logic signed [CoordW-1:0]  CoordMin   = 16'sh8000;

  typedef logic signed [WeightW-1:0] weight_t;
  typedef logic signed [CoordW-1:0]  coord_t;
  typedef logic signed [ProdW-1:0]   prod_t;

  // Stage enables for the weight generator
  typedef struct packed {
    logic tt;     // t squared product
    logic t3;     // t cubed product
    logic wpart;  // w0, w1, w3
    logic wfull;  // w2 and final weight set
  } wgen_en_t;

  // Stage enables for the merging stage
  typedef struct packed {
    logic sum;
    logic out;
  } merge_en_t;

endpackage : crpi_pkg

/* hdl/crpi_weight_gen.sv */
// Basis weight generator: t^2, t^3 and the four Catmull-Rom weights over four stages.
module crpi_weight_gen
  import crpi_pkg::*;
(
  input  logic              clk_i,
  input  wgen_en_t          en_i,
  input  logic [FracW-1:0]  frac_t_i,
  output weight_t           weight_o [NumPts]
);

  logic [2*FracW-1:0] tt_q;
  logic [FracW-1:0]   t1_q;
  logic [2*FracW-1:0] t3p_q;
  logic [FracW-1:0]   t2_q;
  logic [FracW-1:0]   t2t_q;
  weight_t            w0_q, w1_q, w3_q;
  weight_t            w_q [NumPts];

  logic [2*FracW:0]   tt_rnd;
  logic [FracW-1:0]   t2_c;
  logic [2*FracW:0]   t3_rnd;
  logic [FracW-1:0]   t3_c;
  weight_t            t_e, t2_e, t3_e;
  weight_t            w0_c, w1_c, w3_c, w2_c;

  // Round t*t back to Q0.16
  assign tt_rnd = {1'b0, tt_q} + HalfQ16U;
  assign t2_c   = tt_rnd[2*FracW-1:FracW];

  // Round t2*t back to Q0.16
  assign t3_rnd = {1'b0, t3p_q} + HalfQ16U;
  assign t3_c   = t3_rnd[2*FracW-1:FracW];

  // Form w0, w1 and w3 with half-up rounding of the halved terms
  always_comb begin
    t_e  = weight_t'({4'b0, t2t_q});
    t2_e = weight_t'({4'b0, t2_q});
    t3_e = weight_t'({4'b0, t3_c});
    w0_c = t2_e + ((-t3_e - t_e + HalfLsbW) >>> 1);
    w1_c = OneQ16 + (((t3_e <<< 1) + t3_e - (t2_e <<< 2) - t2_e + HalfLsbW) >>> 1);
    w3_c = (t3_e - t2_e + HalfLsbW) >>> 1;
  end

  // Take w2 as one minus the others so the set sums to exactly one
  assign w2_c = OneQ16 - w0_q - w1_q - w3_q;

  // Advance the weight pipeline
  always_ff @(posedge clk_i) begin
    if (en_i.tt) begin
      tt_q <= (2*FracW)'(frac_t_i) * (2*FracW)'(frac_t_i);
      t1_q <= frac_t_i;
    end
    if (en_i.t3) begin
      t3p_q <= (2*FracW)'(t2_c) * (2*FracW)'(t1_q);
      t2_q  <= t2_c;
      t2t_q <= t1_q;
    end
    if (en_i.wpart) begin
      w0_q <= w0_c;
      w1_q <= w1_c;
      w3_q <= w3_c;
    end
    if (en_i.wfull) begin
      w_q[0] <= w0_q;
      w_q[1] <= w1_q;
      w_q[2] <= w2_c;
      w_q[3] <= w3_q;
    end
  end

  assign weight_o = w_q;

endmodule : crpi_weight_gen

/* hdl/crpi_lane.sv */
// One lane: applies one basis weight to the x and y of its control point.
module crpi_lane
  import crpi_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  weight_t weight_i,
  input  coord_t  coord_x_i,
  input  coord_t  coord_y_i,
  output prod_t   prod_x_o,
  output prod_t   prod_y_o
);

  prod_t prod_x_q, prod_y_q;

  // Hold the weighted coordinates for the merging stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_x_q <= prod_t'(weight_i) * prod_t'(coord_x_i);
      prod_y_q <= prod_t'(weight_i) * prod_t'(coord_y_i);
    end
  end

  assign prod_x_o = prod_x_q;
  assign prod_y_o = prod_y_q;

endmodule : crpi_lane

/* hdl/crpi_merge.sv */
// Merging stage: sums the lane products per axis, rounds to nearest and saturates.
module crpi_merge
  import crpi_pkg::*;
(
  input  logic      clk_i,
  input  merge_en_t en_i,
  input  prod_t     prod_x_i [NumPts],
  input  prod_t     prod_y_i [NumPts],
  output coord_t    point_x_o,
  output coord_t    point_y_o
);

  logic signed [SumW-1:0] sum_x_q, sum_y_q;
  logic signed [SumW-1:0] sum_x_c, sum_y_c;
  coord_t                 point_x_q, point_y_q;

  // Round Q.16 to integer, half toward plus infinity, then clamp
  function automatic coord_t round_sat(input logic signed [SumW-1:0] s);
    logic signed [SumW-1:0] r;
    coord_t                 res;
    r = (s + HalfQ16S) >>> 16;
    if (r > CoordMaxS) begin
      res = CoordMax;
    end else if (r < CoordMinS) begin
      res = CoordMin;
    end else begin
      res = r[CoordW-1:0];
    end
    return res;
  endfunction

  // Add the four lane products of each axis
  always_comb begin
    sum_x_c = '0;
    sum_y_c = '0;
    for (int k = 0; k < NumPts; k++) begin
      sum_x_c = sum_x_c + SumW'(prod_x_i[k]);
      sum_y_c = sum_y_c + SumW'(prod_y_i[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      sum_x_q <= sum_x_c;
      sum_y_q <= sum_y_c;
    end
    if (en_i.out) begin
      point_x_q <= round_sat(sum_x_q);
      point_y_q <= round_sat(sum_y_q);
    end
  end

  assign point_x_o = point_x_q;
  assign point_y_o = point_y_q;

endmodule : crpi_merge

/* hdl/catmull_rom_point_interpolator_core.sv */
// Top level of the uniform Catmull-Rom point interpolator.
// Transactions flow through the weight generator, the four lanes and the merging stage;
// one per cycle while the output is not stalled; the lanes weight the points side by side.
// Every stage holds its own valid flag, so bubbles close up while the output is stalled.
// Reset clears only the stage valid flags; the datapath registers are not reset.
module catmull_rom_point_interpolator_core
  import crpi_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // ctrl0_x, ctrl0_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, ctrl3_x, ctrl3_y, frac_t
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // point_x, point_y
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [NumStages:1] valid_q;
  logic [NumStages:1] en;
  logic [CrdW-1:0]    crd_q [1:4];
  weight_t            weight [NumPts];
  prod_t              prod_x [NumPts];
  prod_t              prod_y [NumPts];
  coord_t             point_x, point_y;
  wgen_en_t           wgen_en;
  merge_en_t          merge_en;

  // Let a stage advance when it is empty or its successor advances
  always_comb begin
    en[NumStages] = !valid_q[NumStages] || m_axis_tready_i;
    for (int k = NumStages - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign s_axis_tready_o = en[1];

  // Advance the valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Carry the control points alongside the weight computation
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      crd_q[1] <= s_axis_tdata_i[CrdW-1:0];
    end
    for (int k = 2; k <= 4; k++) begin
      if (en[k]) begin
        crd_q[k] <= crd_q[k-1];
      end
    end
  end

  assign wgen_en = '{tt: en[1], t3: en[2], wpart: en[3], wfull: en[4]};
  assign merge_en = '{sum: en[6], out: en[7]};

  crpi_weight_gen u_weight_gen (
    .clk_i    (clk_i),
    .en_i     (wgen_en),
    .frac_t_i (s_axis_tdata_i[InDataW-1 -: FracW]),
    .weight_o (weight)
  );

  for (genvar g = 0; g < NumPts; g++) begin : g_lane
    crpi_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en[5]),
      .weight_i  (weight[g]),
      .coord_x_i (crd_q[4][2*CoordW*g +: CoordW]),
      .coord_y_i (crd_q[4][2*CoordW*g+CoordW +: CoordW]),
      .prod_x_o  (prod_x[g]),
      .prod_y_o  (prod_y[g])
    );
  end

  crpi_merge u_merge (
    .clk_i     (clk_i),
    .en_i      (merge_en),
    .prod_x_i  (prod_x),
    .prod_y_i  (prod_y),
    .point_x_o (point_x),
    .point_y_o (point_y)
  );

  assign m_axis_tvalid_o = valid_q[NumStages];
  assign m_axis_tdata_o  = {point_y, point_x};

  // An empty output stage leaves the whole pipeline free to take a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled while the output stage is empty");

  // Backpressure reaches the input only when every stage is occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> ($countones(valid_q) == NumStages))
    else $error("input stalled with a bubble in the pipeline");

  // The weights handed to the lanes always sum to exactly one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] |-> ((weight[0] + weight[1] + weight[2] + weight[3]) == OneQ16))
    else $error("basis weights do not sum to one");

endmodule : catmull_rom_point_interpolator_core
